/* rtl/mcbm_pkg.sv */
`timescale 1ns / 1ps

package mcbm_pkg;

  // Memory geometry.
  localparam int unsigned WORK_RAM_DEPTH  = 8192;
  localparam int unsigned VIDEO_RAM_DEPTH = 8192;
  localparam int unsigned WORK_AW  = $clog2(WORK_RAM_DEPTH);
  localparam int unsigned VIDEO_AW = $clog2(VIDEO_RAM_DEPTH);
  localparam int unsigned CLR_DEPTH =
      (WORK_RAM_DEPTH > VIDEO_RAM_DEPTH) ? WORK_RAM_DEPTH : VIDEO_RAM_DEPTH;
  localparam int unsigned CLR_AW = $clog2(CLR_DEPTH);

  // Vector store.
  localparam int unsigned VEC_COUNT = 12;
  localparam int unsigned VEC_AW    = 4;

  // Access modes.
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_FETCH = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_DIP_ONE    = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_DIP_TWO    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_DIP_THREE  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_DEMO_MASK  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_COIN_LIMIT = 3'd4;

  // Address map.
  localparam logic [15:0] VEC_RD_LO    = 16'hFFF2;
  localparam logic [15:0] VEC_RD_HI    = 16'hFFFD;
  localparam logic [15:0] ROM_BASE     = 16'h6000;
  localparam logic [15:0] VIDEO_BASE   = 16'h4000;
  localparam logic [15:0] PORT_DIP_TWO = 16'h3000;
  localparam logic [15:0] PORT_SYSTEM  = 16'h3080;
  localparam logic [15:0] PORT_PLAYER  = 16'h3081;
  localparam logic [15:0] PORT_SPARE   = 16'h3082;
  localparam logic [15:0] PORT_DIP_ONE = 16'h3083;
  localparam logic [15:0] PORT_DIP_THR = 16'h3100;
  localparam logic [15:0] LATCH_LO     = 16'h8080;
  localparam logic [15:0] LATCH_HI     = 16'h8087;
  localparam logic [15:0] SOUND_LATCH  = 16'h8100;
  localparam logic [15:0] VEC_WR_LO    = 16'h8182;
  localparam logic [15:0] VEC_WR_HI    = 16'h818D;
  localparam logic [VIDEO_AW-1:0] GAME_STATE_INDEX = VIDEO_AW'(16'h1002);

  localparam logic [2:0] LATCH_SOUND_TRIG = 3'd1;
  localparam logic [2:0] LATCH_IRQ_EN     = 3'd7;

  typedef enum logic [1:0] {
    SRC_IMM,
    SRC_WORK,
    SRC_VIDEO
  } src_e;

  // One accepted bus transaction, as seen by the register file.
  typedef struct packed {
    logic        valid;
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  rom_byte;
    logic        coin;
    logic        start;
    logic        left;
    logic        right;
    logic        up;
    logic        down;
    logic        fire;
    logic        demo_off;
  } acc_t;

  // Register file answer for the same transaction.
  typedef struct packed {
    logic [7:0] imm_data;
    logic       irq_enable;
    logic       clear_irq;
    logic       sound_req;
    logic [7:0] sound_cmd;
  } res_t;

  function automatic logic is_port(input logic [15:0] a);
    return (a == PORT_DIP_TWO) || (a == PORT_SYSTEM) || (a == PORT_PLAYER) ||
           (a == PORT_SPARE) || (a == PORT_DIP_ONE) || (a == PORT_DIP_THR);
  endfunction

  // Where the read byte of a transaction comes from.
  function automatic src_e ram_src(input logic [1:0] mode, input logic [15:0] a);
    src_e s;
    s = SRC_IMM;
    if (mode == MODE_READ || mode == MODE_FETCH) begin
      if ((a >= VEC_RD_LO && a <= VEC_RD_HI) || a >= ROM_BASE) begin
        s = SRC_IMM;
      end else if (mode == MODE_READ && is_port(a)) begin
        s = SRC_IMM;
      end else if (a >= VIDEO_BASE) begin
        s = SRC_VIDEO;
      end else begin
        s = SRC_WORK;
      end
    end
    return s;
  endfunction

endpackage

/* rtl/mcbm_ram.sv */
`timescale 1ns / 1ps

module mcbm_ram #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mcbm_regs.sv */
`timescale 1ns / 1ps

module mcbm_regs import mcbm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  acc_t              acc_i,
  output res_t              res_o
);

  logic [7:0] dip_one_q, dip_two_q, dip_three_q, demo_mask_q, coin_limit_q;
  logic [7:0] vec_q [VEC_COUNT];
  logic       irq_q, irq_d;
  logic       trig_q, trig_d;
  logic [7:0] snd_q, snd_d;
  logic [7:0] game_state_q;

  logic              wr;
  logic [15:0]       a;
  logic [VEC_AW-1:0] vec_idx;
  logic              vec_hit;
  logic              vec_wr;
  logic              gs_wr;
  logic              latch_wr;
  logic [7:0]        mask;
  logic [7:0]        imm;
  logic              clr, sreq;

  always_comb begin
    a        = acc_i.address;
    wr       = acc_i.valid && acc_i.mode == MODE_WRITE;
    vec_idx  = a[VEC_AW-1:0] - VEC_AW'(2);
    vec_hit  = (a >= VEC_RD_LO) && (a <= VEC_RD_HI);
    vec_wr   = wr && (a >= VEC_WR_LO) && (a <= VEC_WR_HI);
    latch_wr = wr && (a >= LATCH_LO) && (a <= LATCH_HI);
    gs_wr    = wr && (a >= VIDEO_BASE) && (a < ROM_BASE) &&
               (a[VIDEO_AW-1:0] == GAME_STATE_INDEX);
    // The decryption mask depends on address bits 1 and 3.
    mask     = (a[1] ? 8'h80 : 8'h20) | (a[3] ? 8'h08 : 8'h02);

    imm = 8'h00;
    unique case (acc_i.mode)
      MODE_READ: begin
        priority if (vec_hit) begin
          imm = vec_q[vec_idx];
        end else if (a >= ROM_BASE) begin
          imm = acc_i.rom_byte;
        end else if (a == PORT_DIP_TWO) begin
          imm = acc_i.demo_off ? (dip_two_q | demo_mask_q) : (dip_two_q & ~demo_mask_q);
        end else if (a == PORT_SYSTEM) begin
          imm = 8'hFF;
          if (acc_i.coin && game_state_q <= coin_limit_q) imm[0] = 1'b0;
          if (acc_i.start) imm[3] = 1'b0;
        end else if (a == PORT_PLAYER) begin
          imm = {2'b11, ~acc_i.coin, ~acc_i.fire, ~acc_i.down, ~acc_i.up,
                 ~acc_i.right, ~acc_i.left};
        end else if (a == PORT_SPARE) begin
          imm = 8'hFF;
        end else if (a == PORT_DIP_ONE) begin
          imm = dip_one_q;
        end else if (a == PORT_DIP_THR) begin
          imm = dip_three_q;
        end else begin
          imm = 8'h00;
        end
      end
      MODE_FETCH: begin
        priority if (vec_hit) begin
          imm = vec_q[vec_idx];
        end else if (a >= ROM_BASE) begin
          imm = acc_i.rom_byte ^ mask;
        end else begin
          imm = 8'h00;
        end
      end
      default: imm = 8'h00;
    endcase

    irq_d  = irq_q;
    trig_d = trig_q;
    snd_d  = snd_q;
    clr    = 1'b0;
    sreq   = 1'b0;
    if (latch_wr) begin
      if (a[2:0] == LATCH_SOUND_TRIG) begin
        sreq   = acc_i.write_data[0] && !trig_q;
        trig_d = acc_i.write_data[0];
      end else if (a[2:0] == LATCH_IRQ_EN) begin
        irq_d = acc_i.write_data[0];
        clr   = !acc_i.write_data[0];
      end
    end
    if (wr && a == SOUND_LATCH) begin
      snd_d = acc_i.write_data;
    end
  end

  assign res_o = '{imm_data:   imm,
                   irq_enable: irq_d,
                   clear_irq:  clr,
                   sound_req:  sreq,
                   sound_cmd:  snd_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dip_one_q    <= 8'h00;
      dip_two_q    <= 8'h00;
      dip_three_q  <= 8'h00;
      demo_mask_q  <= 8'h00;
      coin_limit_q <= 8'h02;
      irq_q        <= 1'b0;
      trig_q       <= 1'b0;
      snd_q        <= 8'h00;
      game_state_q <= 8'h00;
      for (int i = 0; i < VEC_COUNT; i++) begin
        vec_q[i] <= 8'h00;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_DIP_ONE:    dip_one_q    <= cfg_data_i;
          CFG_DIP_TWO:    dip_two_q    <= cfg_data_i;
          CFG_DIP_THREE:  dip_three_q  <= cfg_data_i;
          CFG_DEMO_MASK:  demo_mask_q  <= cfg_data_i;
          CFG_COIN_LIMIT: coin_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      irq_q  <= irq_d;
      trig_q <= trig_d;
      snd_q  <= snd_d;
      if (gs_wr) begin
        game_state_q <= acc_i.write_data;
      end
      if (vec_wr) begin
        vec_q[vec_idx] <= acc_i.write_data;
      end
    end
  end

endmodule

/* rtl/main_cpu_bus_map_with_decryption.sv */
`timescale 1ns / 1ps

// Main CPU bus decoder. Each input transaction is one bus access (data read,
// opcode fetch or write) and produces exactly one result transaction. Opcode
// fetches from program ROM are decrypted by an XOR mask chosen by address
// bits 1 and 3; the ROM byte itself is supplied with the access. Work RAM
// and video RAM live in two single-port synchronous RAMs; ports, DIP
// switches, the control latch, the sound command latch and the 12-byte
// vector store are flip-flops. A transaction passes through stage one and
// then the output register, and one transaction per cycle is sustained
// while the output is not stalled, since every access makes at most one
// touch of one RAM port and a write lands before the next access reads.
// After reset the block zeroes both RAMs, one address per cycle, over all
// CLR_DEPTH addresses (8192 with the default depths); in_ready_o stays
// low during this pass, while configuration writes are taken as ever.
// A stalled result holds the output register and the stage behind it, and
// beyond that pass, new transactions are held off only while both are full.

module main_cpu_bus_map_with_decryption import mcbm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  logic [15:0]       address_i,
  input  logic [7:0]        write_data_i,
  input  logic [7:0]        rom_byte_i,
  input  logic              coin_button_i,
  input  logic              start_button_i,
  input  logic              left_button_i,
  input  logic              right_button_i,
  input  logic              up_button_i,
  input  logic              down_button_i,
  input  logic              fire_button_i,
  input  logic              demo_sound_off_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        read_data_o,
  output logic              irq_enable_o,
  output logic              clear_main_irq_o,
  output logic              sound_irq_request_o,
  output logic [7:0]        sound_command_o
);

  // Clearing pass state.
  logic              clr_busy_q;
  logic [CLR_AW-1:0] clr_cnt_q;

  // Stage one holds an accepted transaction while its RAM read completes.
  logic       s1_valid_q;
  src_e       s1_src_q;
  logic [7:0] s1_imm_q;
  logic       s1_irq_q, s1_clr_q, s1_sreq_q;
  logic [7:0] s1_snd_q;

  // Output register.
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       out_irq_q, out_clr_q, out_sreq_q;
  logic [7:0] out_snd_q;

  logic       accept;
  logic       s1_adv;
  src_e       src;
  logic       wr_work, wr_video;
  logic [7:0] s1_data;
  logic [7:0] work_rdata, video_rdata;
  acc_t       acc;
  res_t       res;

  // Stage one may hand its result on when the output register is free or
  // is being emptied in this cycle; the RAM output holds until then because
  // no new access is issued.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign accept     = in_valid_i && in_ready_o;

  assign src      = ram_src(mode_i, address_i);
  assign wr_work  = accept && mode_i == MODE_WRITE && address_i < VIDEO_BASE;
  assign wr_video = accept && mode_i == MODE_WRITE && address_i >= VIDEO_BASE &&
                    address_i < ROM_BASE;

  assign acc = '{valid:      accept,
                 mode:       mode_i,
                 address:    address_i,
                 write_data: write_data_i,
                 rom_byte:   rom_byte_i,
                 coin:       coin_button_i,
                 start:      start_button_i,
                 left:       left_button_i,
                 right:      right_button_i,
                 up:         up_button_i,
                 down:       down_button_i,
                 fire:       fire_button_i,
                 demo_off:   demo_sound_off_i};

  mcbm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (acc),
    .res_o       (res)
  );

  // Work RAM is mirrored below the video window, so its index is simply the
  // low address bits. During the clearing pass the sweep owns both ports.
  mcbm_ram #(.DEPTH(WORK_RAM_DEPTH), .WIDTH(8)) u_work_ram (
    .clk_i   (clk_i),
    .en_i    (clr_busy_q || wr_work || (accept && src == SRC_WORK)),
    .we_i    (clr_busy_q || wr_work),
    .addr_i  (clr_busy_q ? clr_cnt_q[WORK_AW-1:0] : address_i[WORK_AW-1:0]),
    .wdata_i (clr_busy_q ? 8'h00 : write_data_i),
    .rdata_o (work_rdata)
  );

  mcbm_ram #(.DEPTH(VIDEO_RAM_DEPTH), .WIDTH(8)) u_video_ram (
    .clk_i   (clk_i),
    .en_i    (clr_busy_q || wr_video || (accept && src == SRC_VIDEO)),
    .we_i    (clr_busy_q || wr_video),
    .addr_i  (clr_busy_q ? clr_cnt_q[VIDEO_AW-1:0] : address_i[VIDEO_AW-1:0]),
    .wdata_i (clr_busy_q ? 8'h00 : write_data_i),
    .rdata_o (video_rdata)
  );

  always_comb begin
    unique case (s1_src_q)
      SRC_WORK:  s1_data = work_rdata;
      SRC_VIDEO: s1_data = video_rdata;
      SRC_IMM:   s1_data = s1_imm_q;
      default:   s1_data = s1_imm_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + CLR_AW'(1);
        if (clr_cnt_q == CLR_AW'(CLR_DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_src_q  <= src;
      s1_imm_q  <= res.imm_data;
      s1_irq_q  <= res.irq_enable;
      s1_clr_q  <= res.clear_irq;
      s1_sreq_q <= res.sound_req;
      s1_snd_q  <= res.sound_cmd;
    end
    if (s1_adv) begin
      out_data_q <= s1_data;
      out_irq_q  <= s1_irq_q;
      out_clr_q  <= s1_clr_q;
      out_sreq_q <= s1_sreq_q;
      out_snd_q  <= s1_snd_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign read_data_o         = out_data_q;
  assign irq_enable_o        = out_irq_q;
  assign clear_main_irq_o    = out_clr_q;
  assign sound_irq_request_o = out_sreq_q;
  assign sound_command_o     = out_snd_q;

`ifndef SYNTHESIS
  // No transaction may be taken while the RAMs are still being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_ready_o)
    else $error("transaction accepted during RAM clearing pass");

  // A pending transaction in stage one is never dropped while it stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("stage one lost a pending transaction");

  // Disabling the interrupt always leaves the enable low in the same result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clear_main_irq_o |-> !irq_enable_o)
    else $error("clear_main_irq reported with irq_enable high");

  // Interrupt side effects come only from writes, whose read byte is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (clear_main_irq_o || sound_irq_request_o) |-> read_data_o == 8'h00)
    else $error("write side effect reported with nonzero read data");
`endif

endmodule
